// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files of the priority task queue.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define PTQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("ptq assertion failed");

// Antecedent implies consequent in the same cycle.
`define PTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ptq assertion failed");

// Antecedent implies consequent in the following cycle.
`define PTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ptq assertion failed");

`endif

// ===== rtl/core/ptq_pkg.sv =====
// Shared types, codes and constants of the priority task queue.
// No dependencies; used by the interfaces and all modules.
package ptq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 32;

    localparam int ID_W     = 8;
    localparam int PRIO_W   = 4;
    localparam int BURST_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic do_add;
        logic emit_entry;
        logic emit_empty;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_sched;
        logic tab_empty;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/ptq_if.sv =====
// Request and response channel interfaces of the priority task queue.
// Depends on ptq_pkg.
interface ptq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [ptq_pkg::ID_W-1:0]     task_id;
    logic [ptq_pkg::PRIO_W-1:0]   priority_req;
    logic [ptq_pkg::BURST_W-1:0]  burst;

    modport source (output valid, opcode, task_id, priority_req, burst, input ready);
    modport sink   (input valid, opcode, task_id, priority_req, burst, output ready);
endinterface

interface ptq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptq_pkg::STATUS_W-1:0]  status;
    logic [ptq_pkg::ID_W-1:0]      task_id_res;
    logic [ptq_pkg::BURST_W-1:0]   burst_res;
    logic                          last;

    modport source (output valid, status, task_id_res, burst_res, last, input ready);
    modport sink   (input valid, status, task_id_res, burst_res, last, output ready);
endinterface

// ===== rtl/core/ptq_datapath.sv =====
// Task table, sorted insert, rotating schedule readout and output register.
// Depends on ptq_pkg; driven by ptq_ctrl through t_cmd, reports t_sts.
module ptq_datapath #(
    parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptq_pkg::t_cmd                 i_cmd,
    output ptq_pkg::t_sts                 o_sts,
    input  logic                          i_opcode,
    input  logic [ptq_pkg::ID_W-1:0]      i_task_id,
    input  logic [ptq_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [ptq_pkg::BURST_W-1:0]   i_burst,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptq_pkg::STATUS_W-1:0]  o_status,
    output logic [ptq_pkg::ID_W-1:0]      o_task_id_res,
    output logic [ptq_pkg::BURST_W-1:0]   o_burst_res,
    output logic                          o_last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    // Captured request.
    logic                 r_op;
    ptq_pkg::t_entry      r_new;

    ptq_pkg::t_entry      r_tab [QUEUE_DEPTH];
    ptq_pkg::t_entry      n_tab [QUEUE_DEPTH];
    ptq_pkg::t_entry      w_up  [QUEUE_DEPTH];
    ptq_pkg::t_entry      w_dn  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_ge;
    logic [QUEUE_DEPTH-1:0] w_prev_ge;

    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 w_full;
    logic                 w_idx_last;
    logic                 w_out_free;

    logic                           r_out_valid, n_out_valid;
    logic [ptq_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [ptq_pkg::ID_W-1:0]       r_id_res, n_id_res;
    logic [ptq_pkg::BURST_W-1:0]    r_burst_res, n_burst_res;
    logic                           r_last, n_last;

    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_idx_last = (CW'(r_idx) == (r_count - CW'(1)));
    assign w_out_free = !r_out_valid || i_ready;

    assign o_sts.is_sched  = (r_op == ptq_pkg::OP_SCHED);
    assign o_sts.tab_empty = (r_count == '0);
    assign o_sts.idx_last  = w_idx_last;
    assign o_sts.out_free  = w_out_free;

    // Neighbor taps: entry below for an insert shift, entry above for rotation.
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_taps
            if (g == 0) begin : g_first
                assign w_up[g]      = r_new;
                assign w_prev_ge[g] = 1'b1;
            end else begin : g_rest
                assign w_up[g]      = r_tab[g-1];
                assign w_prev_ge[g] = w_ge[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_top
                assign w_dn[g] = r_tab[0];
            end else begin : g_mid
                assign w_dn[g] = r_tab[g+1];
            end
            // Stored entries of equal or higher priority stay in place.
            assign w_ge[g] = (CW'(g) < r_count) && (r_tab[g].prio >= r_new.prio);
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_tab[i] = r_tab[i];
        end
        if (i_cmd.capture) begin
            n_idx = '0;
        end
        if (i_cmd.do_add && !w_full) begin
            n_count = r_count + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (!w_ge[i]) begin
                    n_tab[i] = w_prev_ge[i] ? r_new : w_up[i];
                end
            end
        end
        // Readout rotates the occupied part by one; after a full pass the
        // table is back in its original order.
        if (i_cmd.emit_entry) begin
            n_idx = r_idx + IW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                n_tab[i] = (CW'(i) == (r_count - CW'(1))) ? r_tab[0] : w_dn[i];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_id_res    = r_id_res;
        n_burst_res = r_burst_res;
        n_last      = r_last;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.do_add) begin
            n_out_valid = 1'b1;
            n_status    = w_full ? ptq_pkg::ST_REJECTED : ptq_pkg::ST_ACCEPTED;
            n_id_res    = '0;
            n_burst_res = '0;
            n_last      = 1'b1;
        end else if (i_cmd.emit_empty) begin
            n_out_valid = 1'b1;
            n_status    = ptq_pkg::ST_EMPTY;
            n_id_res    = '0;
            n_burst_res = '0;
            n_last      = 1'b1;
        end else if (i_cmd.emit_entry) begin
            n_out_valid = 1'b1;
            n_status    = ptq_pkg::ST_ENTRY;
            n_id_res    = r_tab[0].id;
            n_burst_res = r_tab[0].burst;
            n_last      = w_idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_op        <= ptq_pkg::OP_ADD;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cmd.capture) begin
                r_op <= i_opcode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new.id    <= i_task_id;
            r_new.prio  <= i_priority_req;
            r_new.burst <= i_burst;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_tab[i] <= n_tab[i];
        end
        r_status    <= n_status;
        r_id_res    <= n_id_res;
        r_burst_res <= n_burst_res;
        r_last      <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_task_id_res = r_id_res;
    assign o_burst_res   = r_burst_res;
    assign o_last        = r_last;

endmodule

// ===== rtl/core/ptq_ctrl.sv =====
// Controller state machine of the priority task queue.
// Depends on ptq_pkg; commands ptq_datapath through t_cmd and reads t_sts.
module ptq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  ptq_pkg::t_sts  i_sts,
    output ptq_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Each step waits until the output register can take a result.
                if (i_sts.out_free) begin
                    if (!i_sts.is_sched) begin
                        o_cmd.do_add = 1'b1;
                        n_state      = S_IDLE;
                    end else if (i_sts.tab_empty) begin
                        o_cmd.emit_empty = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_cmd.emit_entry = 1'b1;
                        if (i_sts.idx_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/priority_task_queue_top.sv =====
// Priority task queue: stable sorted task table with add and schedule requests.
// Channels: i_req (sink) carries opcode, task_id, priority_req and burst;
// o_rsp (source) carries status, task_id_res, burst_res and last, with
// valid/ready on both. A request is taken when valid and ready are high.
// An add request inserts the task behind all stored tasks of equal or higher
// priority and answers accepted, or rejected when the table holds QUEUE_DEPTH
// tasks. A schedule request emits every stored task from highest priority down,
// one per cycle while the receiver does not stall, marking the final one with
// last; the table rotates during the readout and ends unchanged. An empty table
// answers with a single empty result.
// One request is handled at a time. The first result is registered in the
// output register from the execute state that follows acceptance, once that
// register is free.
// A stalled receiver holds the output register and freezes the readout;
// a new request is still accepted while the final result waits.
// Reset clears the task count and the output valid; the table needs no
// clearing pass because only the first count entries are ever read.
// Depends on ptq_pkg, ptq_if, ptq_ctrl, ptq_datapath and assert_macros.svh.
`include "assert_macros.svh"

module priority_task_queue_top #(
    parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ptq_req_if.sink   i_req,
    ptq_rsp_if.source o_rsp
);

    ptq_pkg::t_cmd w_cmd;
    ptq_pkg::t_sts w_sts;
    logic          w_req_ready;
    logic [2:0]    w_loads;

    assign i_req.ready = w_req_ready;
    assign w_loads     = {w_cmd.do_add, w_cmd.emit_entry, w_cmd.emit_empty};

    ptq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ptq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_req.opcode),
        .i_task_id      (i_req.task_id),
        .i_priority_req (i_req.priority_req),
        .i_burst        (i_req.burst),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_task_id_res  (o_rsp.task_id_res),
        .o_burst_res    (o_rsp.burst_res),
        .o_last         (o_rsp.last)
    );

    // Only one request is in flight: the cycle after acceptance is never ready.
    `PTQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && w_req_ready, !w_req_ready)
    // Results are loaded only into a free output register.
    `PTQ_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, |w_loads, w_sts.out_free)
    // At most one kind of result is produced per cycle.
    `PTQ_ASSERT_ALWAYS(a_one_result_kind, i_clk, i_rst_n, $onehot0(w_loads))

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of priority_task_queue_top: stable sorted task table.
// Predicts every response from its own task table and checks each one in order.
// Depends on ptq_pkg, ptq_if and the RTL of priority_task_queue_top.
module tb;

    localparam int DEPTH        = 32;
    localparam int N_RANDOM     = 120;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE1_START = 45;
    localparam int PHASE2_START = 90;

    typedef struct {
        logic                         opcode;
        logic [ptq_pkg::ID_W-1:0]     task_id;
        logic [ptq_pkg::PRIO_W-1:0]   prio;
        logic [ptq_pkg::BURST_W-1:0]  burst;
        bit                           drain_first;
    } t_task_req;

    typedef struct packed {
        logic [ptq_pkg::STATUS_W-1:0] status;
        logic [ptq_pkg::ID_W-1:0]     task_id;
        logic [ptq_pkg::BURST_W-1:0]  burst;
        logic                         last;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ptq_req_if req_if ();
    ptq_rsp_if rsp_if ();

    priority_task_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_task_req       pending_req[$];
    t_sched_result   expected_rsp[$];
    ptq_pkg::t_entry task_table[DEPTH];
    int              task_count;
    int              n_accepted;
    int              n_errors;
    int              stall_cycles;
    logic            results_drained;
    bit              hold_back;
    t_task_req       next_req;

    // Idle rates per phase: sender-heavy stalls on the receiver first, then swapped,
    // then a stretch with no idling at all.
    function automatic int sender_idle_pct();
        if (n_accepted < PHASE1_START) return 14;
        if (n_accepted < PHASE2_START) return 51;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_accepted < PHASE1_START) return 51;
        if (n_accepted < PHASE2_START) return 14;
        return 0;
    endfunction

    function automatic t_sched_result make_result(logic [ptq_pkg::STATUS_W-1:0] status,
                                                  logic [ptq_pkg::ID_W-1:0] id,
                                                  logic [ptq_pkg::BURST_W-1:0] burst,
                                                  logic last);
        t_sched_result r;
        r.status  = status;
        r.task_id = id;
        r.burst   = burst;
        r.last    = last;
        return r;
    endfunction

    // Stable insert: a new task goes behind every stored task of equal or higher priority.
    task automatic predict_request(input logic op, input logic [ptq_pkg::ID_W-1:0] id,
                                   input logic [ptq_pkg::PRIO_W-1:0] prio,
                                   input logic [ptq_pkg::BURST_W-1:0] burst);
        int pos;
        int i;
        if (op == ptq_pkg::OP_ADD) begin
            if (task_count >= DEPTH) begin
                expected_rsp.push_back(make_result(ptq_pkg::ST_REJECTED, '0, '0, 1'b1));
            end else begin
                pos = 0;
                while (pos < task_count && task_table[pos].prio >= prio) pos++;
                for (i = task_count; i > pos; i--) task_table[i] = task_table[i-1];
                task_table[pos].id    = id;
                task_table[pos].prio  = prio;
                task_table[pos].burst = burst;
                task_count++;
                expected_rsp.push_back(make_result(ptq_pkg::ST_ACCEPTED, '0, '0, 1'b1));
            end
        end else if (task_count == 0) begin
            expected_rsp.push_back(make_result(ptq_pkg::ST_EMPTY, '0, '0, 1'b1));
        end else begin
            for (i = 0; i < task_count; i++)
                expected_rsp.push_back(make_result(ptq_pkg::ST_ENTRY, task_table[i].id,
                                                   task_table[i].burst,
                                                   (i == task_count - 1)));
        end
    endtask

    task automatic check_result();
        t_sched_result got;
        t_sched_result want;
        got = make_result(rsp_if.status, rsp_if.task_id_res, rsp_if.burst_res, rsp_if.last);
        if (expected_rsp.size() == 0) begin
            if (n_errors < 10)
                $display("unexpected response: status=%0d id=%0d burst=%0d last=%0d",
                         got.status, got.task_id, got.burst, got.last);
            n_errors++;
        end else begin
            want = expected_rsp.pop_front();
            if (got !== want) begin
                if (n_errors < 10)
                    $display({"response mismatch: expected status=%0d id=%0d burst=%0d ",
                              "last=%0d, got status=%0d id=%0d burst=%0d last=%0d"},
                             want.status, want.task_id, want.burst, want.last,
                             got.status, got.task_id, got.burst, got.last);
                n_errors++;
            end
        end
    endtask

    function automatic t_task_req make_req(logic op, int id, int prio, int burst, bit drain);
        t_task_req r;
        r.opcode      = op;
        r.task_id     = id[ptq_pkg::ID_W-1:0];
        r.prio        = prio[ptq_pkg::PRIO_W-1:0];
        r.burst       = burst[ptq_pkg::BURST_W-1:0];
        r.drain_first = drain;
        return r;
    endfunction

    // Request driver. Valid stays up until the request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            // A request that must wait for a drained pipe also waits out the one
            // being taken at this edge, whose results are not yet predicted.
            hold_back = pending_req.size() == 0 ||
                        (pending_req[0].drain_first &&
                         (!results_drained || (req_if.valid && req_if.ready)));
            if (!hold_back && $urandom_range(99) >= sender_idle_pct()) begin
                next_req = pending_req.pop_front();
                req_if.valid        <= 1'b1;
                req_if.opcode       <= next_req.opcode;
                req_if.task_id      <= next_req.task_id;
                req_if.priority_req <= next_req.prio;
                req_if.burst        <= next_req.burst;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response monitor, predictor and watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready    <= 1'b0;
            n_accepted      <= 0;
            stall_cycles    <= 0;
            results_drained <= 1'b1;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request(req_if.opcode, req_if.task_id, req_if.priority_req,
                                req_if.burst);
                n_accepted <= n_accepted + 1;
            end
            if (rsp_if.valid && rsp_if.ready) check_result();
            results_drained <= (expected_rsp.size() == 0);
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or response moved");
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.opcode       = ptq_pkg::OP_ADD;
        req_if.task_id      = '0;
        req_if.priority_req = '0;
        req_if.burst        = '0;
        rsp_if.ready        = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int k;
        task_count = 0;
        n_errors   = 0;
        for (k = 0; k < DEPTH; k++) task_table[k] = '0;

        // Directed: empty schedule, field extremes, ties at both ends of the
        // priority range, ignored fields on schedule.
        pending_req.push_back(make_req(ptq_pkg::OP_SCHED, 0, 0, 0, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 0, 0, 0, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 255, 15, 65535, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 8'h5a, 15, 16'h1234, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 8'ha5, 0, 16'h8001, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 7, 8, 1, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 8, 8, 2, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_SCHED, 0, 0, 0, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_SCHED, 255, 15, 65535, 1));
        pending_req.push_back(make_req(ptq_pkg::OP_ADD, 1, 7, 16'h7fff, 0));
        pending_req.push_back(make_req(ptq_pkg::OP_SCHED, 8'h33, 4'h9, 16'hbeef, 0));

        // Random: adds outnumber schedules so the table fills up and rejects.
        // Priorities often come from a narrow set to build long runs of ties.
        for (k = 0; k < N_RANDOM; k++) begin
            pending_req.push_back(make_req(
                ($urandom_range(99) < 30) ? ptq_pkg::OP_SCHED : ptq_pkg::OP_ADD,
                $urandom_range(255),
                ($urandom_range(1) == 1) ? (($urandom_range(1) == 1) ? 3 : 9)
                                         : $urandom_range(15),
                ($urandom_range(9) == 0) ? (($urandom_range(1) == 1) ? 65535 : 0)
                                         : $urandom_range(65535),
                (pending_req.size() == PHASE1_START || pending_req.size() == PHASE2_START ||
                 pending_req.size() == 70)));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_req.size() != 0 || req_if.valid || expected_rsp.size() != 0);
        repeat (10) @(negedge i_clk);

        if (n_errors == 0 && expected_rsp.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
